// ----- hw/rtl/sose_pkg.sv -----
// ----------------------------------------------------------------------------
// sose_pkg
// Opcodes and result status codes shared by the set-of-stacks engine.
// ----------------------------------------------------------------------------
package sose_pkg;

    typedef enum logic [1:0] {
        OP_PUSH    = 2'd0,
        OP_POP     = 2'd1,
        OP_POP_AT  = 2'd2,
        OP_PEEK    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_INVALID   = 2'd3
    } status_t;

endpackage

// ----- hw/rtl/set_of_stacks_engine.sv -----
// ----------------------------------------------------------------------------
// set_of_stacks_engine
// Array of bounded stacks acting as one large stack, with push, pop,
// pop from a numbered stack and peek.
// ----------------------------------------------------------------------------
// The engine takes one beat per clock cycle while the result side does not stall,
// and returns one result beat for each, passing through the input register and
// then the result register. All words live in one memory with a single write port
// and a single registered read port; a push writes it and a pop or peek reads
// it in the same cycle the per-stack fill counters and current-stack pointer
// are updated, so a beat sees everything left by the beat before it. Stalls
// on the result side hold the result and then the input register.
module set_of_stacks_engine #(
    parameter int NUM_STACKS  = 8,
    parameter int STACK_DEPTH = 8
) (
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         opcode,
    input  logic signed [31:0] push_value,
    input  logic [3:0]         stack_number,

    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] read_value,
    output logic [1:0]         status,
    output logic               is_empty,
    output logic               is_full
);

    localparam int SW    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CW    = $clog2(STACK_DEPTH + 1);
    localparam int WORDS = NUM_STACKS * STACK_DEPTH;
    localparam int AW    = $clog2(WORDS);
    localparam int NW    = (SW + 1 > 5) ? SW + 1 : 5;

    localparam logic [SW-1:0] LAST_STACK = SW'(NUM_STACKS - 1);
    localparam logic [CW-1:0] FULL_CNT   = CW'(STACK_DEPTH);
    localparam logic [NW-1:0] NUM_LIMIT  = NW'(NUM_STACKS);

    // Input register
    logic                in_vld_reg;
    sose_pkg::opcode_t   op_reg;
    logic signed [31:0]  val_reg;
    logic [3:0]          num_reg;

    // Engine state
    logic [CW-1:0]       fill_reg [NUM_STACKS];
    logic [SW-1:0]       cur_reg;
    logic [SW-1:0]       cur_next;
    logic signed [31:0]  mem [WORDS];

    // Result register
    logic                out_vld_reg;
    logic signed [31:0]  rd_data_reg;
    logic                rd_ok_reg;
    sose_pkg::status_t   st_reg;
    logic                empty_reg;
    logic                full_reg;

    logic                adv;
    logic                go;

    // Step logic
    logic [CW-1:0]       f_cur;
    logic                all_empty;
    logic                all_full;
    logic [SW-1:0]       s_sel;
    logic [CW-1:0]       f_sel;
    logic [NW-1:0]       num_w;
    logic [NW-1:0]       cur_p1;
    sose_pkg::status_t   st_next;
    logic                rd_ok_next;
    logic                wr_en;
    logic                cnt_upd;
    logic [CW-1:0]       cnt_new;
    logic [CW-1:0]       pos;
    logic [AW-1:0]       addr;
    logic [CW-1:0]       f0_next;
    logic [CW-1:0]       fl_next;

    // Advance when the result register is free or being taken
    assign adv      = !out_vld_reg || !out_stall;
    assign go       = in_vld_reg && adv;
    assign in_stall = in_vld_reg && !adv;

    // Decode the operation against the current state
    always_comb
    begin
        f_cur      = fill_reg[cur_reg];
        all_empty  = (cur_reg == '0) && (f_cur == '0);
        all_full   = (cur_reg == LAST_STACK) && (f_cur == FULL_CNT);
        num_w      = NW'(num_reg);
        cur_p1     = NW'(cur_reg) + NW'(1);
        s_sel      = cur_reg;
        cur_next   = cur_reg;
        st_next    = sose_pkg::ST_OK;
        rd_ok_next = 1'b0;
        wr_en      = 1'b0;
        cnt_upd    = 1'b0;

        case (op_reg)
            sose_pkg::OP_PUSH:
            begin
                if (f_cur >= FULL_CNT)
                begin
                    s_sel = cur_reg + SW'(1);
                end
            end
            sose_pkg::OP_POP, sose_pkg::OP_PEEK:
            begin
                if (f_cur == '0)
                begin
                    s_sel = cur_reg - SW'(1);
                end
            end
            sose_pkg::OP_POP_AT:
            begin
                s_sel = SW'(num_w - NW'(1));
            end
            default:
            begin
                s_sel = cur_reg;
            end
        endcase

        f_sel = fill_reg[s_sel];

        case (op_reg)
            sose_pkg::OP_PUSH:
            begin
                if (all_full)
                begin
                    st_next = sose_pkg::ST_OVERFLOW;
                end
                else
                begin
                    cur_next = s_sel;
                    wr_en    = 1'b1;
                    cnt_upd  = 1'b1;
                end
            end
            sose_pkg::OP_POP:
            begin
                if (all_empty)
                begin
                    st_next = sose_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    cur_next = s_sel;
                    if (f_sel == '0)
                    begin
                        st_next = sose_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        rd_ok_next = 1'b1;
                        cnt_upd    = 1'b1;
                    end
                end
            end
            sose_pkg::OP_POP_AT:
            begin
                if (num_w == '0 || num_w > cur_p1 || num_w > NUM_LIMIT)
                begin
                    st_next = sose_pkg::ST_INVALID;
                end
                else if (f_sel == '0)
                begin
                    st_next = sose_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    rd_ok_next = 1'b1;
                    cnt_upd    = 1'b1;
                end
            end
            sose_pkg::OP_PEEK:
            begin
                if (all_empty || f_sel == '0)
                begin
                    st_next = sose_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    rd_ok_next = 1'b1;
                end
            end
            default:
            begin
                st_next = sose_pkg::ST_OK;
            end
        endcase

        // Push fills the next free slot, reads take the top slot
        cnt_new = wr_en ? (f_sel + CW'(1)) : (f_sel - CW'(1));
        pos     = wr_en ? f_sel : (f_sel - CW'(1));
        addr    = AW'(s_sel) * AW'(STACK_DEPTH) + AW'(pos);

        // Fill counts of the first and last stacks after the step
        f0_next = (cnt_upd && s_sel == '0) ? cnt_new : fill_reg[0];
        fl_next = (cnt_upd && s_sel == LAST_STACK) ? cnt_new : fill_reg[NUM_STACKS-1];
    end

    // Capture an input beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_vld_reg <= 1'b1;
        end
        else if (adv)
        begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            op_reg  <= sose_pkg::opcode_t'(opcode);
            val_reg <= push_value;
            num_reg <= stack_number;
        end
    end

    // Update fill counts and current stack
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_STACKS; i++)
            begin
                fill_reg[i] <= '0;
            end
            cur_reg <= '0;
        end
        else if (go)
        begin
            if (cnt_upd)
            begin
                fill_reg[s_sel] <= cnt_new;
            end
            cur_reg <= cur_next;
        end
    end

    // Word storage: write on push, registered read for pop and peek
    always_ff @(posedge clk)
    begin
        if (go)
        begin
            if (wr_en)
            begin
                mem[addr] <= val_reg;
            end
            rd_data_reg <= mem[addr];
        end
    end

    // Hold the result until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rd_ok_reg <= rd_ok_next;
            st_reg    <= st_next;
            empty_reg <= (cur_next == '0) && (f0_next == '0);
            full_reg  <= (cur_next == LAST_STACK) && (fl_next == FULL_CNT);
        end
    end

    assign out_valid  = out_vld_reg;
    assign read_value = rd_ok_reg ? rd_data_reg : 32'sd0;
    assign status     = st_reg;
    assign is_empty   = empty_reg;
    assign is_full    = full_reg;

endmodule

// ----- tb/tb_set_of_stacks_engine.sv -----
// ----------------------------------------------------------------------------
// tb_set_of_stacks_engine
// Self-checking bench for the set-of-stacks engine. A behavioural model of
// the stacks predicts every result beat from the beats the engine accepts;
// the results are compared field by field in order. Directed cases cover
// the empty and partly emptied stacks, then random traffic fills the whole
// set to overflow, drains it to underflow, and mixes all four operations with
// and without random idling and under a long result-side hold-off.
// ----------------------------------------------------------------------------
module tb_set_of_stacks_engine;

    localparam int NUM_STACKS  = 8;
    localparam int STACK_DEPTH = 8;
    localparam int CYCLE_LIMIT = 60000;

    typedef struct {
        logic signed [31:0] word;
        sose_pkg::status_t  status;
        logic               empty_flag;
        logic               full_flag;
    } result_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         opcode;
    logic signed [31:0] push_value;
    logic [3:0]         stack_number;
    logic               out_valid;
    logic               out_stall;
    logic signed [31:0] read_value;
    logic [1:0]         status;
    logic               is_empty;
    logic               is_full;

    // Model state of the stacks
    logic signed [31:0] model_words [NUM_STACKS][STACK_DEPTH];
    int                 model_fill  [NUM_STACKS];
    int                 model_cur;

    result_t predicted_results [$];
    int      mismatch_count;
    int      cycle_count;
    bit      idle_on;
    int      hold_request;
    int      hold_left;
    int      result_gap;

    set_of_stacks_engine #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .push_value   (push_value),
        .stack_number (stack_number),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .read_value   (read_value),
        .status       (status),
        .is_empty     (is_empty),
        .is_full      (is_full)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Behavioural model
    // ------------------------------------------------------------------
    function automatic bit model_empty();
        return model_cur == 0 && model_fill[0] == 0;
    endfunction

    function automatic bit model_full();
        return model_cur == NUM_STACKS - 1 && model_fill[NUM_STACKS - 1] == STACK_DEPTH;
    endfunction

    function automatic result_t stack_model_step(sose_pkg::opcode_t op,
                                                 logic signed [31:0] value,
                                                 logic [3:0] num);
        result_t r;
        int      s;
        r.word   = '0;
        r.status = sose_pkg::ST_OK;
        case (op)
            sose_pkg::OP_PUSH:
            begin
                if (model_full())
                    r.status = sose_pkg::ST_OVERFLOW;
                else
                begin
                    // advance to the next stack when the current one is full
                    if (model_fill[model_cur] >= STACK_DEPTH)
                        model_cur++;
                    model_words[model_cur][model_fill[model_cur]] = value;
                    model_fill[model_cur]++;
                end
            end
            sose_pkg::OP_POP:
            begin
                if (model_empty())
                    r.status = sose_pkg::ST_UNDERFLOW;
                else
                begin
                    // step back once only, and keep the step even if that stack is empty
                    if (model_fill[model_cur] == 0)
                        model_cur--;
                    if (model_fill[model_cur] == 0)
                        r.status = sose_pkg::ST_UNDERFLOW;
                    else
                    begin
                        model_fill[model_cur]--;
                        r.word = model_words[model_cur][model_fill[model_cur]];
                    end
                end
            end
            sose_pkg::OP_POP_AT:
            begin
                if (num == 0 || num > model_cur + 1 || num > NUM_STACKS)
                    r.status = sose_pkg::ST_INVALID;
                else
                begin
                    s = num - 1;
                    if (model_fill[s] == 0)
                        r.status = sose_pkg::ST_UNDERFLOW;
                    else
                    begin
                        model_fill[s]--;
                        r.word = model_words[s][model_fill[s]];
                    end
                end
            end
            default:
            begin
                // peek looks below an empty current stack but never moves
                if (model_empty())
                    r.status = sose_pkg::ST_UNDERFLOW;
                else
                begin
                    s = model_cur;
                    if (model_fill[s] == 0)
                        s--;
                    if (model_fill[s] == 0)
                        r.status = sose_pkg::ST_UNDERFLOW;
                    else
                        r.word = model_words[s][model_fill[s] - 1];
                end
            end
        endcase
        r.empty_flag = model_empty();
        r.full_flag  = model_full();
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Input side: send one beat, predict on acceptance
    // ------------------------------------------------------------------
    task automatic issue_op(sose_pkg::opcode_t op, logic signed [31:0] value,
                            logic [3:0] num);
        int gap;
        gap = idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        push_value   <= value;
        stack_number <= num;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predicted_results.push_back(stack_model_step(op, value, num));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (predicted_results.size() != 0)
            @(negedge clk);
    endtask

    // pick a pop_at number, mostly within the legal range
    function automatic logic [3:0] pick_stack_number();
        if ($urandom_range(0, 9) < 7)
            return 4'($urandom_range(1, model_cur + 1));
        return 4'($urandom_range(0, 15));
    endfunction

    // ------------------------------------------------------------------
    // Output side: hold-off and per-beat stalls
    // ------------------------------------------------------------------
    initial
    begin
        out_stall = 1'b0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (result_gap > 0)
            begin
                out_stall <= 1'b1;
                result_gap--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Compare each accepted result beat with the oldest prediction
    always @(posedge clk)
    begin : check_result
        result_t want;
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            result_gap = idle_on ? $urandom_range(0, 4) : 0;
            if (predicted_results.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result beat, read_value %0d status %0d",
                         $time, read_value, status);
            end
            else
            begin
                want = predicted_results.pop_front();
                if (read_value !== want.word)
                begin
                    mismatch_count++;
                    $display("%0t: read_value expected %0d actual %0d",
                             $time, want.word, read_value);
                end
                if (status !== want.status)
                begin
                    mismatch_count++;
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, status);
                end
                if (is_empty !== want.empty_flag)
                begin
                    mismatch_count++;
                    $display("%0t: is_empty expected %0b actual %0b",
                             $time, want.empty_flag, is_empty);
                end
                if (is_full !== want.full_flag)
                begin
                    mismatch_count++;
                    $display("%0t: is_full expected %0b actual %0b",
                             $time, want.full_flag, is_full);
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty set, stepping back across stacks, and pop_at leaving holes
    task automatic test_directed();
        logic signed [31:0] extremes [4];
        extremes = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1};
        issue_op(sose_pkg::OP_POP, 32'sh0, 4'd0);
        issue_op(sose_pkg::OP_PEEK, 32'sh0, 4'd0);
        issue_op(sose_pkg::OP_POP_AT, 32'sh0, 4'd0);
        issue_op(sose_pkg::OP_POP_AT, 32'sh0, 4'd1);
        issue_op(sose_pkg::OP_POP_AT, 32'sh0, 4'd2);
        // nine pushes spill into the second stack
        for (int i = 0; i < 9; i++)
            issue_op(sose_pkg::OP_PUSH, (i < 4) ? extremes[i] : 32'($urandom),
                     4'($urandom));
        issue_op(sose_pkg::OP_POP, 32'sh0, 4'd0);
        issue_op(sose_pkg::OP_PEEK, 32'sh0, 4'd0);
        issue_op(sose_pkg::OP_POP_AT, 32'sh0, 4'd3);
        issue_op(sose_pkg::OP_POP_AT, 32'sh0, 4'd2);
        // empty the first stack from underneath
        repeat (STACK_DEPTH) issue_op(sose_pkg::OP_POP_AT, 32'sh0, 4'd1);
        issue_op(sose_pkg::OP_PEEK, 32'sh0, 4'd0);
        issue_op(sose_pkg::OP_POP, 32'sh0, 4'd0);
        issue_op(sose_pkg::OP_PUSH, 32'sh7FFF_FFFF, 4'hF);
        issue_op(sose_pkg::OP_POP_AT, 32'sh0, 4'hF);
    endtask

    // Fill the whole set past overflow, then drain past underflow
    task automatic test_fill_and_drain();
        int guard;
        guard = 0;
        while (!model_full() && guard < 200)
        begin
            if ($urandom_range(0, 9) == 0)
                issue_op(sose_pkg::OP_PEEK, 32'($urandom), 4'($urandom));
            else
                issue_op(sose_pkg::OP_PUSH, 32'($urandom), 4'($urandom));
            guard++;
        end
        repeat (2) issue_op(sose_pkg::OP_PUSH, 32'($urandom), 4'($urandom));
        issue_op(sose_pkg::OP_PEEK, 32'($urandom), 4'($urandom));
        guard = 0;
        while (!model_empty() && guard < 200)
        begin
            if ($urandom_range(0, 9) == 0)
                issue_op(sose_pkg::OP_POP_AT, 32'($urandom), pick_stack_number());
            else
                issue_op(sose_pkg::OP_POP, 32'($urandom), 4'($urandom));
            guard++;
        end
        repeat (2) issue_op(sose_pkg::OP_POP, 32'($urandom), 4'($urandom));
    endtask

    // Hold results back long enough to back the engine up, then drain
    task automatic test_backpressure();
        hold_request = 40;
        repeat (20) issue_op(sose_pkg::opcode_t'($urandom_range(0, 3)), 32'($urandom),
                             pick_stack_number());
        wait_drained();
    endtask

    // Weighted mix of all operations with random content
    task automatic test_random_mix(int count);
        int                pick;
        sose_pkg::opcode_t op;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 42)
                op = sose_pkg::OP_PUSH;
            else if (pick < 67)
                op = sose_pkg::OP_POP;
            else if (pick < 87)
                op = sose_pkg::OP_POP_AT;
            else
                op = sose_pkg::OP_PEEK;
            issue_op(op, 32'($urandom), pick_stack_number());
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        opcode         = sose_pkg::OP_PUSH;
        push_value     = '0;
        stack_number   = '0;
        mismatch_count = 0;
        cycle_count    = 0;
        idle_on        = 1'b1;
        hold_request   = 0;
        result_gap     = 0;
        for (int s = 0; s < NUM_STACKS; s++)
            model_fill[s] = 0;
        model_cur = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_fill_and_drain();
        test_backpressure();
        // run a stretch with no idling on either side
        idle_on = 1'b0;
        test_random_mix(80);
        idle_on = 1'b1;
        test_fill_and_drain();
        test_random_mix(250);
        wait_drained();

        repeat (10) @(negedge clk);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/sose_pkg.sv
hw/rtl/set_of_stacks_engine.sv
tb/tb_set_of_stacks_engine.sv
